/* rtl/rc4kg_pkg.sv */
// Shared types and constants for the RC4 keystream generator.
// No dependencies; every other file in rtl/ refers to this package by scoped name.
package rc4kg_pkg;

	localparam int PermDepth  = 256;
	localparam int ByteW      = 8;
	localparam int KeyLenW    = 5;
	localparam int KeyIdxW    = 4;
	localparam int CfgDataW   = 64;
	localparam int CfgIndexW  = 2;
	localparam logic [KeyLenW-1:0] KeyBytesMax = 5'd16;

	// configuration register indexes
	localparam logic [CfgIndexW-1:0] REG_KEY_LENGTH    = 2'd0;
	localparam logic [CfgIndexW-1:0] REG_KEY_WORD_LOW  = 2'd1;
	localparam logic [CfgIndexW-1:0] REG_KEY_WORD_HIGH = 2'd2;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_START,   // clear indices and counters
		OP_FILL,    // S[n] = n, advance n
		OP_KRD_N,   // read S[n]
		OP_KRD_J,   // j += S[n] + key, read S[j]
		OP_KWR_N,   // S[n] = S[j]
		OP_KWR_J,   // S[j] = old S[n], advance n and key index
		OP_GRD_I,   // i += 1, read S[i]
		OP_GRD_J,   // j += S[i], read S[j]
		OP_GWR_I,   // S[i] = S[j]
		OP_GWR_J,   // S[j] = old S[i]
		OP_GRD_O,   // read S[S[i] + S[j]]
		OP_LOAD     // move read data to the output register
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic n_last;    // sweep counter at its last entry
		logic keyed;     // a key schedule has completed
		logic out_free;  // output register can take a byte this cycle
	} stat_t;

endpackage

/* rtl/rc4kg_ctrl.sv */
// Sequencer for the RC4 keystream generator: fill, key schedule and keystream step.
// Depends on rc4kg_pkg (op_t, cmd_t, stat_t).
module rc4kg_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             rekey,
	output logic             in_ready,
	input  rc4kg_pkg::stat_t stat,
	output rc4kg_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_FILL,
		ST_K_RD_N,
		ST_K_RD_J,
		ST_K_WR_N,
		ST_K_WR_J,
		ST_G_RD_I,
		ST_G_RD_J,
		ST_G_WR_I,
		ST_G_WR_J,
		ST_G_RD_O,
		ST_G_OUT
	} state_t;

	state_t          state_q;
	rc4kg_pkg::op_t  op_q;

	assign in_ready = (state_q == ST_IDLE);
	assign cmd.op   = op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= rc4kg_pkg::OP_NONE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (rekey || !stat.keyed) begin
							state_q <= ST_START;
							op_q    <= rc4kg_pkg::OP_START;
						end else begin
							state_q <= ST_G_RD_I;
							op_q    <= rc4kg_pkg::OP_GRD_I;
						end
					end
				end
				ST_START: begin
					state_q <= ST_FILL;
					op_q    <= rc4kg_pkg::OP_FILL;
				end
				ST_FILL: begin
					if (stat.n_last) begin
						state_q <= ST_K_RD_N;
						op_q    <= rc4kg_pkg::OP_KRD_N;
					end
				end
				ST_K_RD_N: begin
					state_q <= ST_K_RD_J;
					op_q    <= rc4kg_pkg::OP_KRD_J;
				end
				ST_K_RD_J: begin
					state_q <= ST_K_WR_N;
					op_q    <= rc4kg_pkg::OP_KWR_N;
				end
				ST_K_WR_N: begin
					state_q <= ST_K_WR_J;
					op_q    <= rc4kg_pkg::OP_KWR_J;
				end
				ST_K_WR_J: begin
					if (stat.n_last) begin
						state_q <= ST_G_RD_I;
						op_q    <= rc4kg_pkg::OP_GRD_I;
					end else begin
						state_q <= ST_K_RD_N;
						op_q    <= rc4kg_pkg::OP_KRD_N;
					end
				end
				ST_G_RD_I: begin
					state_q <= ST_G_RD_J;
					op_q    <= rc4kg_pkg::OP_GRD_J;
				end
				ST_G_RD_J: begin
					state_q <= ST_G_WR_I;
					op_q    <= rc4kg_pkg::OP_GWR_I;
				end
				ST_G_WR_I: begin
					state_q <= ST_G_WR_J;
					op_q    <= rc4kg_pkg::OP_GWR_J;
				end
				ST_G_WR_J: begin
					state_q <= ST_G_RD_O;
					op_q    <= rc4kg_pkg::OP_GRD_O;
				end
				ST_G_RD_O: begin
					state_q <= ST_G_OUT;
					op_q    <= rc4kg_pkg::OP_LOAD;
				end
				ST_G_OUT: begin
					// hold until the output register frees up
					if (stat.out_free) begin
						state_q <= ST_IDLE;
						op_q    <= rc4kg_pkg::OP_NONE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					op_q    <= rc4kg_pkg::OP_NONE;
				end
			endcase
		end
	end

endmodule

/* rtl/rc4kg_datapath.sv */
// Datapath for the RC4 keystream generator: permutation memory, indices,
// key registers and output register. Depends on rc4kg_pkg.
module rc4kg_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [rc4kg_pkg::CfgIndexW-1:0]    cfg_index,
	input  logic [rc4kg_pkg::CfgDataW-1:0]     cfg_data,
	input  rc4kg_pkg::cmd_t                    cmd,
	output rc4kg_pkg::stat_t                   stat,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic [rc4kg_pkg::ByteW-1:0]        keystream_byte
);

	localparam int AddrW = $clog2(rc4kg_pkg::PermDepth);

	logic [rc4kg_pkg::ByteW-1:0]     mem_q [rc4kg_pkg::PermDepth];
	logic [rc4kg_pkg::ByteW-1:0]     rdata_q;

	logic [AddrW-1:0]                i_q, j_q, n_q;
	logic [rc4kg_pkg::KeyIdxW-1:0]   k_q;
	logic                            keyed_q;
	logic [rc4kg_pkg::ByteW-1:0]     si_q, sj_q;
	logic                            out_valid_q;
	logic [rc4kg_pkg::ByteW-1:0]     out_byte_q;

	logic [rc4kg_pkg::KeyLenW-1:0]   key_len_q;
	logic [rc4kg_pkg::CfgDataW-1:0]  key_lo_q, key_hi_q;

	logic [rc4kg_pkg::KeyLenW-1:0]   len_eff;
	logic                            k_wrap;
	logic [2*rc4kg_pkg::CfgDataW-1:0] key_all;
	logic [rc4kg_pkg::ByteW-1:0]     key_byte;
	logic [AddrW-1:0]                i_next, ksa_j, prga_j, out_addr;
	logic                            ren, we;
	logic [AddrW-1:0]                raddr, waddr;
	logic [rc4kg_pkg::ByteW-1:0]     wdata;
	logic                            out_free;

	// saturate key length to 1..16
	always_comb begin
		if (key_len_q == '0) begin
			len_eff = rc4kg_pkg::KeyLenW'(1);
		end else if (key_len_q > rc4kg_pkg::KeyBytesMax) begin
			len_eff = rc4kg_pkg::KeyBytesMax;
		end else begin
			len_eff = key_len_q;
		end
	end

	assign k_wrap   = ({1'b0, k_q} == (len_eff - rc4kg_pkg::KeyLenW'(1)));
	assign key_all  = {key_hi_q, key_lo_q};
	assign key_byte = key_all[{k_q, 3'b000} +: rc4kg_pkg::ByteW];

	assign i_next   = i_q + AddrW'(1);
	assign ksa_j    = j_q + rdata_q + key_byte;
	assign prga_j   = j_q + rdata_q;
	assign out_addr = si_q + sj_q;

	assign out_free = !out_valid_q || out_ready;

	assign stat.n_last   = (n_q == AddrW'(rc4kg_pkg::PermDepth - 1));
	assign stat.keyed    = keyed_q;
	assign stat.out_free = out_free;

	assign out_valid      = out_valid_q;
	assign keystream_byte = out_byte_q;

	// memory port selection
	always_comb begin
		ren   = 1'b0;
		raddr = '0;
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		case (cmd.op)
			rc4kg_pkg::OP_FILL: begin
				we    = 1'b1;
				waddr = n_q;
				wdata = n_q;
			end
			rc4kg_pkg::OP_KRD_N: begin
				ren   = 1'b1;
				raddr = n_q;
			end
			rc4kg_pkg::OP_KRD_J: begin
				ren   = 1'b1;
				raddr = ksa_j;
			end
			rc4kg_pkg::OP_KWR_N: begin
				we    = 1'b1;
				waddr = n_q;
				wdata = rdata_q;
			end
			rc4kg_pkg::OP_KWR_J: begin
				we    = 1'b1;
				waddr = j_q;
				wdata = si_q;
			end
			rc4kg_pkg::OP_GRD_I: begin
				ren   = 1'b1;
				raddr = i_next;
			end
			rc4kg_pkg::OP_GRD_J: begin
				ren   = 1'b1;
				raddr = prga_j;
			end
			rc4kg_pkg::OP_GWR_I: begin
				we    = 1'b1;
				waddr = i_q;
				wdata = rdata_q;
			end
			rc4kg_pkg::OP_GWR_J: begin
				we    = 1'b1;
				waddr = j_q;
				wdata = si_q;
			end
			rc4kg_pkg::OP_GRD_O: begin
				ren   = 1'b1;
				raddr = out_addr;
			end
			default: begin
				ren = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ren) begin
			rdata_q <= mem_q[raddr];
		end
	end

	// indices, counters, flags, output handshake, configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q         <= '0;
			j_q         <= '0;
			n_q         <= '0;
			k_q         <= '0;
			keyed_q     <= 1'b0;
			out_valid_q <= 1'b0;
			key_len_q   <= rc4kg_pkg::KeyLenW'(1);
			key_lo_q    <= '0;
			key_hi_q    <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					rc4kg_pkg::REG_KEY_LENGTH:    key_len_q <= cfg_data[rc4kg_pkg::KeyLenW-1:0];
					rc4kg_pkg::REG_KEY_WORD_LOW:  key_lo_q  <= cfg_data;
					rc4kg_pkg::REG_KEY_WORD_HIGH: key_hi_q  <= cfg_data;
					default: ;
				endcase
			end

			case (cmd.op)
				rc4kg_pkg::OP_START: begin
					i_q <= '0;
					j_q <= '0;
					n_q <= '0;
					k_q <= '0;
				end
				rc4kg_pkg::OP_FILL: begin
					n_q <= n_q + AddrW'(1);
				end
				rc4kg_pkg::OP_KRD_J: begin
					j_q <= ksa_j;
				end
				rc4kg_pkg::OP_KWR_J: begin
					n_q <= n_q + AddrW'(1);
					k_q <= k_wrap ? '0 : k_q + rc4kg_pkg::KeyIdxW'(1);
					if (stat.n_last) begin
						j_q     <= '0;
						keyed_q <= 1'b1;
					end
				end
				rc4kg_pkg::OP_GRD_I: begin
					i_q <= i_next;
				end
				rc4kg_pkg::OP_GRD_J: begin
					j_q <= prga_j;
				end
				default: ;
			endcase

			if (cmd.op == rc4kg_pkg::OP_LOAD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// swap operands and output byte
	always_ff @(posedge clk) begin
		case (cmd.op)
			rc4kg_pkg::OP_KRD_J: si_q <= rdata_q;
			rc4kg_pkg::OP_GRD_J: si_q <= rdata_q;
			rc4kg_pkg::OP_GWR_I: sj_q <= rdata_q;
			rc4kg_pkg::OP_LOAD: begin
				if (out_free) begin
					out_byte_q <= rdata_q;
				end
			end
			default: ;
		endcase
	end

endmodule

/* rtl/rc4_keystream_generator_unit.sv */
// Top level of the RC4 keystream generator: controller plus datapath.
// Depends on rc4kg_pkg, rc4kg_ctrl and rc4kg_datapath.
//
//   Channel  Direction  Handshake               Payload
//   in       sink       in_valid / in_ready     rekey
//   out      source     out_valid / out_ready   keystream_byte
//   cfg      sink       cfg_write               cfg_index, cfg_data
//
// A request without a key schedule runs six steps through the single read / single
// write permutation RAM (read S[i], read S[j], write S[i], write S[j],
// read S[S[i]+S[j]], load output) after the idle state that takes the request.
// A request that runs the schedule (rekey set, or no key yet) first clears the
// indices, then fills all 256 entries with the identity permutation, then runs
// the key-scheduling sweep, four RAM accesses per entry, before the keystream step.
// Reset clears indices, flags, key words and out_valid, sets key length 1; the RAM
// holds garbage until the first schedule writes it, which every first request runs.
// A stalled output only holds the final load step; the next request is taken as
// soon as the byte sits in the output register.
module rc4_keystream_generator_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            rekey,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [rc4kg_pkg::ByteW-1:0]     keystream_byte,
	input  logic                            cfg_write,
	input  logic [rc4kg_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [rc4kg_pkg::CfgDataW-1:0]  cfg_data
);

	rc4kg_pkg::cmd_t  cmd;
	rc4kg_pkg::stat_t stat;

	// sequencer: takes requests and steps the datapath through each phase
	rc4kg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.rekey    (rekey),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// permutation RAM, indices, key storage and output register
	rc4kg_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.stat           (stat),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.keystream_byte (keystream_byte)
	);

endmodule

/* rtl/rc4kg_checker.sv */
// Port-level checks for the RC4 keystream generator, bound to the top level.
// Depends on rc4kg_pkg and rc4_keystream_generator_unit.
module rc4kg_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [rc4kg_pkg::ByteW-1:0] keystream_byte
);

	// a stalled byte holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(keystream_byte))
		else $error("keystream byte dropped or changed while stalled");

	// one request in flight: busy right after taking one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while the previous one is still in work");

	// no byte can appear the cycle after a request is taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("byte appeared too early after a request");

	// a new byte only comes out of a busy block
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("byte appeared without a request in work");

endmodule

bind rc4_keystream_generator_unit rc4kg_checker u_rc4kg_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.keystream_byte (keystream_byte)
);
